>>> hdl/lav_pkg.sv
`timescale 1ns / 1ps
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int UW  = FRAC_BITS + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int VW  = FRAC_BITS + 36;
  localparam int MW  = 31;
  localparam int SW  = 64;
  localparam int LW  = 32;
  localparam int SQS = SW / 2;
  localparam int NW  = MW + FRAC_BITS + 1;
  localparam int DW  = LW + QW;
  localparam int SHW = $clog2(VW + 1);

  localparam int GAP_W = 2;
  localparam logic [GAP_W-1:0] ISSUE_GAP = 2'd3;
  localparam logic [1:0] LAST_COL = 2'd3;

  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
  localparam logic [VW-1:0] HALF = VW'(1) << (FRAC_BITS - 1);
  localparam logic [VW-1:0] POS_LIM = VW'(32'h7FFF_FFFF);
  localparam logic [VW-1:0] NEG_LIM = VW'(1) << 31;

  typedef logic signed [31:0] word_t;
  typedef logic signed [UW-1:0] unit_t;
  typedef logic signed [VW-1:0] wide_t;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] aux;
    logic             ok;
  } side_t;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] r;
    logic [2:0][31:0] u;
    logic [2:0][31:0] f;
    logic [2:0][31:0] t;
    logic             deg;
  } mat_t;

  function automatic wide_t mul(input word_t a, input word_t b);
    logic signed [63:0] p;
    p = a * b;
    return VW'(p);
  endfunction

  function automatic word_t rnd_sat(input wide_t v);
    logic          neg;
    logic [VW-1:0] mg;
    logic [VW-1:0] q;
    word_t         res;
    neg = v[VW-1];
    mg  = neg ? VW'(-v) : VW'(v);
    q   = (mg + HALF) >> FRAC_BITS;
    if (!neg) begin
      res = (q > POS_LIM) ? word_t'(32'h7FFF_FFFF) : word_t'(q[31:0]);
    end else begin
      res = (q > NEG_LIM) ? word_t'(32'h8000_0000) : word_t'(-q[31:0]);
    end
    return res;
  endfunction

endpackage

>>> hdl/lav_unit.sv
`timescale 1ns / 1ps
module lav_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  lav_pkg::wide_t  in_a [3],
  input  lav_pkg::side_t  in_side,
  output logic            out_valid,
  output lav_pkg::unit_t  out_u [3],
  output logic            out_ok,
  output lav_pkg::side_t  out_side
);

  logic                       v1, v2, v3, v4;
  logic [lav_pkg::VW-1:0]     mag1 [3];
  logic [lav_pkg::VW-1:0]     mag2 [3];
  logic [lav_pkg::VW-1:0]     mx2;
  logic [lav_pkg::MW-1:0]     m3 [3];
  logic [lav_pkg::SW-1:0]     sq4 [3];
  logic                       n1 [3], n2 [3], n3 [3], n4 [3];
  lav_pkg::side_t             s1, s2, s3, s4;
  logic [lav_pkg::MW-1:0]     m4 [3];
  logic [lav_pkg::SHW-1:0]    hb;
  logic [lav_pkg::SHW-1:0]    sh;

  logic                       sq_vld [lav_pkg::SQS+1];
  logic [lav_pkg::SW-1:0]     sq_v   [lav_pkg::SQS+1];
  logic [lav_pkg::SW-1:0]     sq_r   [lav_pkg::SQS+1];
  logic [lav_pkg::MW-1:0]     sq_m   [lav_pkg::SQS+1][3];
  logic                       sq_n   [lav_pkg::SQS+1][3];
  lav_pkg::side_t             sq_s   [lav_pkg::SQS+1];

  logic                       dv_vld [lav_pkg::QW+1];
  logic [lav_pkg::NW-1:0]     dv_rem [lav_pkg::QW+1][3];
  logic [lav_pkg::QW-1:0]     dv_q   [lav_pkg::QW+1][3];
  logic [lav_pkg::LW-1:0]     dv_l   [lav_pkg::QW+1];
  logic                       dv_n   [lav_pkg::QW+1][3];
  lav_pkg::side_t             dv_s   [lav_pkg::QW+1];

  logic [lav_pkg::LW-1:0]     root;

  always_comb begin
    hb = '0;
    for (int j = 0; j < lav_pkg::VW; j++) begin
      if (mx2[j]) begin
        hb = lav_pkg::SHW'(j + 1);
      end
    end
    sh = (hb > lav_pkg::SHW'(lav_pkg::MW)) ? hb - lav_pkg::SHW'(lav_pkg::MW) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      sq_vld[0] <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      sq_vld[0] <= v4;
    end
    for (int i = 0; i < 3; i++) begin
      n1[i]   <= in_a[i][lav_pkg::VW-1];
      mag1[i] <= in_a[i][lav_pkg::VW-1] ? lav_pkg::VW'(-in_a[i]) : lav_pkg::VW'(in_a[i]);
      n2[i]   <= n1[i];
      mag2[i] <= mag1[i];
      n3[i]   <= n2[i];
      m3[i]   <= lav_pkg::MW'(mag2[i] >> sh);
      n4[i]   <= n3[i];
      m4[i]   <= m3[i];
      sq4[i]  <= lav_pkg::SW'(m3[i]) * lav_pkg::SW'(m3[i]);
    end
    mx2 <= (mag1[0] > mag1[1]) ? ((mag1[0] > mag1[2]) ? mag1[0] : mag1[2])
                               : ((mag1[1] > mag1[2]) ? mag1[1] : mag1[2]);
    s1 <= in_side;
    s2 <= s1;
    s3 <= s2;
    s4 <= s3;
    sq_v[0] <= sq4[0] + sq4[1] + sq4[2];
    sq_r[0] <= '0;
    sq_m[0] <= m4;
    sq_n[0] <= n4;
    sq_s[0] <= s4;
  end

  for (genvar k = 0; k < lav_pkg::SQS; k++) begin : g_sqrt
    localparam logic [lav_pkg::SW-1:0] BITK = lav_pkg::SW'(1) << (lav_pkg::SW - 2 - 2 * k);
    logic [lav_pkg::SW-1:0] trial;
    assign trial = sq_r[k] + BITK;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else begin
        sq_vld[k+1] <= sq_vld[k];
      end
      if (sq_v[k] >= trial) begin
        sq_v[k+1] <= sq_v[k] - trial;
        sq_r[k+1] <= (sq_r[k] >> 1) + BITK;
      end else begin
        sq_v[k+1] <= sq_v[k];
        sq_r[k+1] <= sq_r[k] >> 1;
      end
      sq_m[k+1] <= sq_m[k];
      sq_n[k+1] <= sq_n[k];
      sq_s[k+1] <= sq_s[k];
    end
  end

  assign root = sq_r[lav_pkg::SQS][lav_pkg::LW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= sq_vld[lav_pkg::SQS];
    end
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= {sq_m[lav_pkg::SQS][i], lav_pkg::FRAC_BITS'(0)}
                      + lav_pkg::NW'(root >> 1);
      dv_q[0][i]   <= '0;
    end
    dv_l[0] <= root;
    dv_n[0] <= sq_n[lav_pkg::SQS];
    dv_s[0] <= sq_s[lav_pkg::SQS];
  end

  for (genvar j = 0; j < lav_pkg::QW; j++) begin : g_div
    localparam int SH = lav_pkg::QW - 1 - j;
    logic [lav_pkg::DW-1:0] dvs;
    assign dvs = lav_pkg::DW'(dv_l[j]) << SH;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j+1] <= 1'b0;
      end else begin
        dv_vld[j+1] <= dv_vld[j];
      end
      for (int i = 0; i < 3; i++) begin
        if (lav_pkg::DW'(dv_rem[j][i]) >= dvs) begin
          dv_rem[j+1][i] <= dv_rem[j][i] - lav_pkg::NW'(dvs);
          dv_q[j+1][i]   <= {dv_q[j][i][lav_pkg::QW-2:0], 1'b1};
        end else begin
          dv_rem[j+1][i] <= dv_rem[j][i];
          dv_q[j+1][i]   <= {dv_q[j][i][lav_pkg::QW-2:0], 1'b0};
        end
      end
      dv_l[j+1] <= dv_l[j];
      dv_n[j+1] <= dv_n[j];
      dv_s[j+1] <= dv_s[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_vld[lav_pkg::QW];
    end
    for (int i = 0; i < 3; i++) begin
      if (dv_l[lav_pkg::QW] == '0) begin
        out_u[i] <= '0;
      end else if (dv_n[lav_pkg::QW][i]) begin
        out_u[i] <= -$signed({1'b0, dv_q[lav_pkg::QW][i]});
      end else begin
        out_u[i] <= $signed({1'b0, dv_q[lav_pkg::QW][i]});
      end
    end
    out_ok   <= (dv_l[lav_pkg::QW] != '0);
    out_side <= dv_s[lav_pkg::QW];
  end

endmodule

>>> hdl/lav_out.sv
`timescale 1ns / 1ps
module lav_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  lav_pkg::mat_t      in_mat,
  input  logic               mode,
  output logic               strobe,
  output logic [1:0]         column_index,
  output logic signed [31:0] entry_row0,
  output logic signed [31:0] entry_row1,
  output logic signed [31:0] entry_row2,
  output logic signed [31:0] entry_row3,
  output logic               last_column,
  output logic               degenerate
);

  logic [2:0][31:0] cols [4];
  logic [1:0]       cnt;
  logic             active;
  logic             deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (in_valid) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      active <= (cnt != lav_pkg::LAST_COL);
      cnt    <= cnt + 2'd1;
    end
    if (in_valid) begin
      deg <= in_mat.deg;
      if (mode) begin
        cols[0] <= in_mat.r;
        cols[1] <= in_mat.u;
        for (int k = 0; k < 3; k++) begin
          cols[2][k] <= 32'(-$signed(in_mat.f[k]));
        end
        cols[3] <= in_mat.eye;
      end else begin
        for (int k = 0; k < 3; k++) begin
          cols[k] <= {32'(-$signed(in_mat.f[k])), in_mat.u[k], in_mat.r[k]};
        end
        cols[3] <= in_mat.t;
      end
    end
  end

  assign strobe       = active;
  assign column_index = cnt;
  assign entry_row0   = $signed(cols[cnt][0]);
  assign entry_row1   = $signed(cols[cnt][1]);
  assign entry_row2   = $signed(cols[cnt][2]);
  assign entry_row3   = (cnt == lav_pkg::LAST_COL) ? $signed(lav_pkg::ONE) : 32'sd0;
  assign last_column  = (cnt == lav_pkg::LAST_COL);
  assign degenerate   = deg;

endmodule

>>> hdl/look_at_view_matrix.sv
`timescale 1ns / 1ps
// Look-at camera matrix, signed Q16.16 throughout.
// Input: drive eye, target and up hint with start; a camera is taken on a
// clock edge with start high and busy low. busy then stays high for the
// issue gap, ISSUE_GAP, which the single result port sets, while up to
// about thirty earlier cameras are still in flight.
// Output: four column transfers per camera, columns 0 to 3 on consecutive
// cycles, each marked by strobe for one cycle; last_column flags column 3
// and degenerate is the same on all four. After the accepting edge a
// camera passes the input register, the forward normalizer, b1, b2, the
// right normalizer, c1 to c6 and the output register; each normalizer is
// a one-bit-per-stage square root followed by a one-bit-per-stage divider.
// give_inverse is written with give_inverse_we: 0 gives the view matrix,
// 1 the camera-to-world matrix. Write it only while no camera is in flight.
// Reset clears all valid bits and the mode; the receiver cannot stall, so
// results are never held back.
module look_at_view_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               give_inverse_we,
  input  logic               give_inverse,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] upward_x,
  input  logic signed [31:0] upward_y,
  input  logic signed [31:0] upward_z,
  output logic               strobe,
  output logic [1:0]         column_index,
  output logic signed [31:0] entry_row0,
  output logic signed [31:0] entry_row1,
  output logic signed [31:0] entry_row2,
  output logic signed [31:0] entry_row3,
  output logic               last_column,
  output logic               degenerate
);

  logic [lav_pkg::GAP_W-1:0] gap;
  logic                      accept;
  logic                      inv_mode;

  logic                      a_vld;
  lav_pkg::wide_t            a_d [3];
  lav_pkg::side_t            a_side;

  logic                      f_vld;
  lav_pkg::unit_t            f_u [3];
  logic                      f_ok;
  lav_pkg::side_t            f_side;

  logic                      b1_vld, b2_vld;
  lav_pkg::wide_t            b1_p [6];
  lav_pkg::side_t            b1_side, b2_side;
  lav_pkg::wide_t            b2_rr [3];

  logic                      r_vld;
  lav_pkg::unit_t            r_u [3];
  logic                      r_ok;
  lav_pkg::side_t            r_side;

  logic                      c1_vld, c2_vld, c3_vld, c4_vld, c5_vld, c6_vld;
  lav_pkg::wide_t            c1_uc [6];
  lav_pkg::wide_t            c1_er [3];
  lav_pkg::wide_t            c1_ef [3];
  lav_pkg::wide_t            c2_ud [3];
  lav_pkg::wide_t            c2_sr, c2_sf;
  lav_pkg::wide_t            c4_eu [3];
  lav_pkg::wide_t            c5_su;
  lav_pkg::mat_t             c1_m, c2_m, c3_m, c4_m, c5_m, c6_m;

  assign accept = start && !busy;
  assign busy   = (gap != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap      <= '0;
      inv_mode <= 1'b0;
      a_vld    <= 1'b0;
    end else begin
      if (accept) begin
        gap <= lav_pkg::ISSUE_GAP;
      end else if (gap != '0) begin
        gap <= gap - lav_pkg::GAP_W'(1);
      end
      if (give_inverse_we) begin
        inv_mode <= give_inverse;
      end
      a_vld <= accept;
    end
    if (accept) begin
      a_d[0] <= lav_pkg::VW'($signed({target_x[31], target_x}) - $signed({eye_x[31], eye_x}));
      a_d[1] <= lav_pkg::VW'($signed({target_y[31], target_y}) - $signed({eye_y[31], eye_y}));
      a_d[2] <= lav_pkg::VW'($signed({target_z[31], target_z}) - $signed({eye_z[31], eye_z}));
      a_side.eye <= {eye_z, eye_y, eye_x};
      a_side.aux <= {upward_z, upward_y, upward_x};
      a_side.ok  <= 1'b1;
    end
  end

  lav_unit u_fwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_vld),
    .in_a      (a_d),
    .in_side   (a_side),
    .out_valid (f_vld),
    .out_u     (f_u),
    .out_ok    (f_ok),
    .out_side  (f_side)
  );

  // right = f x up, exact
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
    end else begin
      b1_vld <= f_vld;
      b2_vld <= b1_vld;
    end
    b1_p[0] <= lav_pkg::mul(32'(f_u[1]), $signed(f_side.aux[2]));
    b1_p[1] <= lav_pkg::mul(32'(f_u[2]), $signed(f_side.aux[1]));
    b1_p[2] <= lav_pkg::mul(32'(f_u[2]), $signed(f_side.aux[0]));
    b1_p[3] <= lav_pkg::mul(32'(f_u[0]), $signed(f_side.aux[2]));
    b1_p[4] <= lav_pkg::mul(32'(f_u[0]), $signed(f_side.aux[1]));
    b1_p[5] <= lav_pkg::mul(32'(f_u[1]), $signed(f_side.aux[0]));
    b1_side.eye <= f_side.eye;
    b1_side.aux <= {32'(f_u[2]), 32'(f_u[1]), 32'(f_u[0])};
    b1_side.ok  <= f_ok;
    b2_rr[0] <= b1_p[0] - b1_p[1];
    b2_rr[1] <= b1_p[2] - b1_p[3];
    b2_rr[2] <= b1_p[4] - b1_p[5];
    b2_side  <= b1_side;
  end

  lav_unit u_right (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b2_vld),
    .in_a      (b2_rr),
    .in_side   (b2_side),
    .out_valid (r_vld),
    .out_u     (r_u),
    .out_ok    (r_ok),
    .out_side  (r_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
      c3_vld <= 1'b0;
      c4_vld <= 1'b0;
      c5_vld <= 1'b0;
      c6_vld <= 1'b0;
    end else begin
      c1_vld <= r_vld;
      c2_vld <= c1_vld;
      c3_vld <= c2_vld;
      c4_vld <= c3_vld;
      c5_vld <= c4_vld;
      c6_vld <= c5_vld;
    end

    c1_uc[0] <= lav_pkg::mul(32'(r_u[1]), $signed(r_side.aux[2]));
    c1_uc[1] <= lav_pkg::mul(32'(r_u[2]), $signed(r_side.aux[1]));
    c1_uc[2] <= lav_pkg::mul(32'(r_u[2]), $signed(r_side.aux[0]));
    c1_uc[3] <= lav_pkg::mul(32'(r_u[0]), $signed(r_side.aux[2]));
    c1_uc[4] <= lav_pkg::mul(32'(r_u[0]), $signed(r_side.aux[1]));
    c1_uc[5] <= lav_pkg::mul(32'(r_u[1]), $signed(r_side.aux[0]));
    for (int i = 0; i < 3; i++) begin
      c1_er[i] <= lav_pkg::mul($signed(r_side.eye[i]), 32'(r_u[i]));
      c1_ef[i] <= lav_pkg::mul($signed(r_side.eye[i]), $signed(r_side.aux[i]));
    end
    c1_m.eye <= r_side.eye;
    c1_m.r   <= {32'(r_u[2]), 32'(r_u[1]), 32'(r_u[0])};
    c1_m.f   <= r_side.aux;
    c1_m.u   <= '0;
    c1_m.t   <= '0;
    c1_m.deg <= !(r_ok && r_side.ok);

    c2_ud[0] <= c1_uc[0] - c1_uc[1];
    c2_ud[1] <= c1_uc[2] - c1_uc[3];
    c2_ud[2] <= c1_uc[4] - c1_uc[5];
    c2_sr    <= c1_er[0] + c1_er[1] + c1_er[2];
    c2_sf    <= c1_ef[0] + c1_ef[1] + c1_ef[2];
    c2_m     <= c1_m;

    // eye . back = -(eye . f), so tz needs no extra negation
    c3_m.eye <= c2_m.eye;
    c3_m.r   <= c2_m.r;
    c3_m.f   <= c2_m.f;
    c3_m.deg <= c2_m.deg;
    for (int i = 0; i < 3; i++) begin
      c3_m.u[i] <= lav_pkg::rnd_sat(c2_ud[i]);
    end
    c3_m.t[0] <= lav_pkg::rnd_sat(-c2_sr);
    c3_m.t[1] <= c2_m.t[1];
    c3_m.t[2] <= lav_pkg::rnd_sat(c2_sf);

    for (int i = 0; i < 3; i++) begin
      c4_eu[i] <= lav_pkg::mul($signed(c3_m.eye[i]), $signed(c3_m.u[i]));
    end
    c4_m <= c3_m;

    c5_su <= c4_eu[0] + c4_eu[1] + c4_eu[2];
    c5_m  <= c4_m;

    c6_m.eye  <= c5_m.eye;
    c6_m.r    <= c5_m.r;
    c6_m.u    <= c5_m.u;
    c6_m.f    <= c5_m.f;
    c6_m.deg  <= c5_m.deg;
    c6_m.t[0] <= c5_m.t[0];
    c6_m.t[1] <= lav_pkg::rnd_sat(-c5_su);
    c6_m.t[2] <= c5_m.t[2];
  end

  lav_out u_out (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (c6_vld),
    .in_mat       (c6_m),
    .mode         (inv_mode),
    .strobe       (strobe),
    .column_index (column_index),
    .entry_row0   (entry_row0),
    .entry_row1   (entry_row1),
    .entry_row2   (entry_row2),
    .entry_row3   (entry_row3),
    .last_column  (last_column),
    .degenerate   (degenerate)
  );

endmodule

>>> hdl/lav_chk.sv
`timescale 1ns / 1ps
module lav_chk (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [1:0] column_index,
  input logic       degenerate
);

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##1 busy ##1 busy)
    else $error("busy dropped inside the issue gap");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer in");

  a_col_seq: assert property (@(posedge clk) disable iff (rst)
    strobe && column_index != lav_pkg::LAST_COL
      |=> strobe && column_index == 2'($past(column_index) + 2'd1))
    else $error("column sequence broken");

  a_deg_same: assert property (@(posedge clk) disable iff (rst)
    strobe && column_index != 2'd0 |-> $past(strobe) && $stable(degenerate))
    else $error("degenerate changed within one camera");

endmodule

bind look_at_view_matrix lav_chk u_lav_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .column_index (column_index),
  .degenerate   (degenerate)
);
